FILE: rtl/mandel_pkg.sv
`default_nettype none

package mandel_pkg;

  // Field widths of the stream payloads
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned COORD_W = 32;

  // Largest image side; indices at or above it are clamped
  localparam int unsigned MAX_DIM = 4096;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_X_ORIGIN = 3'd0,
    CFG_Y_ORIGIN = 3'd1,
    CFG_X_STEP   = 3'd2,
    CFG_Y_STEP   = 3'd3,
    CFG_MAX_ITER = 3'd4
  } cfg_index_t;

  // Register reset values
  localparam logic [COORD_W-1:0] X_ORIGIN_RST = 32'hC000_0000;
  localparam logic [COORD_W-1:0] Y_ORIGIN_RST = 32'hC000_0000;
  localparam logic [COORD_W-1:0] X_STEP_RST   = 32'd4294967;
  localparam logic [COORD_W-1:0] Y_STEP_RST   = 32'd4294967;
  localparam logic [COUNT_W-1:0] MAX_ITER_RST = 16'd1000;

endpackage

`default_nettype wire

FILE: rtl/mandelbrot_escape_time_pixel.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tdata[11:0] pixel_column, [23:12] pixel_row
// m_*       out  tvalid/tready      tdata[15:0] iteration_count, [23:16] gray_level
// cfg_*     in   cfg_we (no stall)  cfg_index selects register, cfg_data value
//
// Per pixel: map the point on the one registered multiplier (S_CX, S_CY, S_CW), run each
// iteration as S_TEST, S_XX, S_YY, S_XY, make a final test, set up the divider, take 8
// restoring divide steps, load the output and go idle; escape by |z|^2 leaves from S_YY.
// s_tready is high only in idle; a result waits in the output register, so the next
// pixel is taken while m_tready is low, and its result stalls until the slot frees.
// rst is synchronous; it resets the configuration registers, state and m_tvalid.
module mandelbrot_escape_time_pixel
  import mandel_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // pixel_column [11:0], pixel_row [23:12]
  input  wire logic [23:0]         s_tdata,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // iteration_count [15:0], gray_level [23:16]
  output logic [23:0]              m_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [COORD_W-1:0]  cfg_data
);

  // Working width holds +-(4 << FRAC_BITS) + 2^31 and twice a product
  localparam int unsigned WW = ((FRAC_BITS + 3 > COORD_W) ? FRAC_BITS + 3 : COORD_W) + 2;
  // Multiplier operand width: magnitudes up to 2 << FRAC_BITS, or a step
  localparam int unsigned MW = (FRAC_BITS + 2 > COORD_W) ? FRAC_BITS + 2 : COORD_W;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned SW = COORD_W + INDEX_W + 1;   // origin + index*step
  localparam logic [WW-1:0] TWO  = WW'(64'd2 << FRAC_BITS);
  localparam logic [WW-1:0] FOUR = WW'(64'd4 << FRAC_BITS);
  localparam logic [INDEX_W-1:0] IDX_MAX =
    (MAX_DIM > 4096) ? {INDEX_W{1'b1}} : INDEX_W'(MAX_DIM - 1);
  localparam logic [SW-1:0] SAT_HI = SW'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic [SW-1:0] SAT_LO = {{(SW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_CX, S_CY, S_CW, S_TEST, S_XX, S_YY, S_XY, S_DINIT, S_DIV, S_OUT
  } state_t;

  // Configuration registers
  logic [COORD_W-1:0] x_origin, y_origin, x_step, y_step;
  logic [COUNT_W-1:0] iter_limit;

  // Working registers
  state_t             state;
  logic [INDEX_W-1:0] col, row;
  logic [COUNT_W-1:0] mx, count;
  logic [WW-1:0]      cx, cy, x, y, xx, yy;
  logic [PW-1:0]      prod;
  logic [23:0]        rem;
  logic [GRAY_W-1:0]  quo;
  logic [2:0]         k;

  // Combinational helpers
  logic [MW-1:0]      a_op, b_op;
  logic [WW-1:0]      ax, ay, yy_c, xy_c, sxy, x_next, y_next;
  logic [COORD_W-1:0] xs_mag, ys_mag;
  logic [SW-1:0]      cprod, csum;
  logic [WW-1:0]      coord;
  logic [INDEX_W-1:0] col_in, row_in;
  logic [23:0]        dsub;
  logic               escape_pre, escape_sq;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin   <= X_ORIGIN_RST;
      y_origin   <= Y_ORIGIN_RST;
      x_step     <= X_STEP_RST;
      y_step     <= Y_STEP_RST;
      iter_limit <= MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_ORIGIN: x_origin   <= cfg_data;
        CFG_Y_ORIGIN: y_origin   <= cfg_data;
        CFG_X_STEP:   x_step     <= cfg_data;
        CFG_Y_STEP:   y_step     <= cfg_data;
        CFG_MAX_ITER: iter_limit <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp indices to the image size
  assign col_in = (s_tdata[11:0] > IDX_MAX)  ? IDX_MAX : s_tdata[11:0];
  assign row_in = (s_tdata[23:12] > IDX_MAX) ? IDX_MAX : s_tdata[23:12];

  // Magnitudes of the steps and of the working point
  assign xs_mag = x_step[COORD_W-1] ? (~x_step + 1'b1) : x_step;
  assign ys_mag = y_step[COORD_W-1] ? (~y_step + 1'b1) : y_step;
  assign ax     = x[WW-1] ? (~x + 1'b1) : x;
  assign ay     = y[WW-1] ? (~y + 1'b1) : y;

  // Select the operands of the shared multiplier
  always_comb begin
    unique case (state)
      S_CX:    begin a_op = MW'(xs_mag); b_op = MW'(col);    end
      S_CY:    begin a_op = MW'(ys_mag); b_op = MW'(row);    end
      S_XX:    begin a_op = ay[MW-1:0];  b_op = ay[MW-1:0];  end
      S_YY:    begin a_op = ax[MW-1:0];  b_op = ay[MW-1:0];  end
      default: begin a_op = ax[MW-1:0];  b_op = ax[MW-1:0];  end
    endcase
  end

  // Map the product of index and step to a saturated coordinate
  always_comb begin
    logic neg;
    neg   = (state == S_CY) ? x_step[COORD_W-1] : y_step[COORD_W-1];
    cprod = neg ? (~SW'(prod[SW-2:0]) + 1'b1) : SW'(prod[SW-2:0]);
    csum  = cprod + ((state == S_CY) ? SW'($signed(x_origin)) : SW'($signed(y_origin)));
    if ($signed(csum) > $signed(SAT_HI)) begin
      coord = WW'($signed(SAT_HI[COORD_W-1:0]));
    end else if ($signed(csum) < $signed(SAT_LO)) begin
      coord = WW'($signed(SAT_LO[COORD_W-1:0]));
    end else begin
      coord = WW'($signed(csum[COORD_W-1:0]));
    end
  end

  // Iteration arithmetic
  assign escape_pre = (count >= mx) || (ax > TWO) || (ay > TWO);
  assign yy_c       = WW'(prod >> FRAC_BITS);
  assign escape_sq  = (xx + yy_c) > FOUR;
  assign xy_c       = WW'(prod >> FRAC_BITS);
  assign sxy        = (x[WW-1] != y[WW-1]) ? (~xy_c + 1'b1) : xy_c;
  assign x_next     = xx - yy + cx;
  assign y_next     = (sxy << 1) + cy;

  // Divider trial subtrahend
  assign dsub = 24'({8'd0, mx}) << k;

  assign s_tready = (state == S_IDLE) && !rst;

  // Sequence the pixel through mapping, iteration and gray division
  always_ff @(posedge clk) begin
    prod <= PW'(a_op * b_op);
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            col   <= col_in;
            row   <= row_in;
            mx    <= iter_limit;
            state <= S_CX;
          end
        end
        S_CX: state <= S_CY;
        S_CY: begin
          cx    <= coord;
          state <= S_CW;
        end
        S_CW: begin
          cy    <= coord;
          x     <= cx;
          y     <= coord;
          count <= '0;
          state <= S_TEST;
        end
        S_TEST: state <= escape_pre ? S_DINIT : S_XX;
        S_XX: begin
          xx    <= WW'(prod >> FRAC_BITS);
          state <= S_YY;
        end
        S_YY: begin
          yy    <= yy_c;
          state <= escape_sq ? S_DINIT : S_XY;
        end
        S_XY: begin
          x     <= x_next;
          y     <= y_next;
          count <= count + 1'b1;
          state <= S_TEST;
        end
        S_DINIT: begin
          rem   <= {count, 8'd0} - {8'd0, count};
          quo   <= '0;
          k     <= 3'd7;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem >= dsub) begin
            rem    <= rem - dsub;
            quo[k] <= 1'b1;
          end
          if (k == 3'd0) begin
            state <= S_OUT;
          end
          k <= k - 1'b1;
        end
        S_OUT: begin
          // Load the output register once the previous result is gone
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {(mx == '0) ? GRAY_W'(0) : quo, count};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A taken pixel always starts with the column product
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_CX))
    else $error("accepted pixel did not start mapping");

  // Squaring only runs on a point inside the early escape box
  a_operand_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_XX) |-> ((ax <= TWO) && (ay <= TWO)))
    else $error("multiplier operand exceeds two");

  // The count never passes the latched limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_TEST || state == S_OUT) |-> (count <= mx))
    else $error("iteration count beyond limit");

  // The divider finishes with a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && mx != '0) |-> (rem < 24'(mx)))
    else $error("gray division remainder too large");

endmodule

`default_nettype wire
